[src/ipv4cv_pkg.sv]
// Shared types and constants for the IPv4 CIDR text validator.
package ipv4cv_pkg;

   // ASCII codes the scanner looks for.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Limits and saturation points of the accumulators.
   localparam logic [8:0] OCTET_MAX      = 9'd255;
   localparam logic [8:0] OCTET_SAT      = 9'd256;
   localparam logic [5:0] PREFIX_MAX     = 6'd32;
   localparam logic [5:0] PREFIX_SAT     = 6'd33;
   localparam logic [2:0] OCTET_COUNT    = 3'd4;
   localparam logic [2:0] OCTETS_SAT     = 3'd7;
   localparam logic [1:0] PREFIX_CNT_SAT = 2'd3;

   // Classification of one character.
   typedef struct packed {
      logic       is_digit;
      logic       is_dot;
      logic       is_slash;
      logic [3:0] digit_val;
   } char_class_type;

   // Verdict produced by the scanner for one transfer.
   typedef struct packed {
      logic done;
      logic cidr_valid;
   } verdict_type;

endpackage

[src/ipv4cv_char_class.sv]
// Character classifier: digit, dot and slash detection with digit value.
module ipv4cv_char_class (
   input  logic [7:0]                 ch,
   output ipv4cv_pkg::char_class_type char_class
);
   import ipv4cv_pkg::*;

   logic [7:0] diff;

   // Compare against the ASCII codes and take the digit value from the offset.
   always_comb begin
      diff                 = ch - CH_ZERO;
      char_class.is_digit  = ch inside {[CH_ZERO:CH_NINE]};
      char_class.is_dot    = (ch == CH_DOT);
      char_class.is_slash  = (ch == CH_SLASH);
      char_class.digit_val = char_class.is_digit ? diff[3:0] : 4'd0;
   end

endmodule

[src/ipv4cv_scan.sv]
// Scanner state: octet and prefix accumulators, and the end-of-string verdict.
module ipv4cv_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       end_marker,
   input  ipv4cv_pkg::char_class_type char_class,
   output ipv4cv_pkg::verdict_type    verdict
);
   import ipv4cv_pkg::*;

   logic       in_prefix_ff, in_prefix_in;
   logic [8:0] octet_value_ff, octet_value_in;
   logic       octet_has_digit_ff, octet_has_digit_in;
   logic [2:0] octets_seen_ff, octets_seen_in;
   logic [5:0] prefix_value_ff, prefix_value_in;
   logic [1:0] prefix_digit_count_ff, prefix_digit_count_in;
   logic       prefix_starts_zero_ff, prefix_starts_zero_in;
   logic       string_bad_ff, string_bad_in;

   logic [12:0] octet_wide;
   logic [8:0]  prefix_wide;
   logic        octet_bad;
   logic [2:0]  octets_closed;
   logic        prefix_ok;
   logic        ok;

   // Closing an octet flags it bad when empty or above 255, and counts it.
   always_comb begin
      octet_wide    = 13'(octet_value_ff) * 13'd10 + 13'(char_class.digit_val);
      prefix_wide   = 9'(prefix_value_ff) * 9'd10 + 9'(char_class.digit_val);
      octet_bad     = !octet_has_digit_ff || (octet_value_ff > OCTET_MAX);
      octets_closed = (octets_seen_ff < OCTETS_SAT) ? octets_seen_ff + 3'd1
                                                    : octets_seen_ff;
      prefix_ok     = (prefix_digit_count_ff != 2'd0) &&
                      (prefix_value_ff <= PREFIX_MAX) &&
                      !((prefix_digit_count_ff > 2'd1) && prefix_starts_zero_ff);
   end

   // Verdict on an end marker; the address-only case closes the last octet.
   always_comb begin
      if (in_prefix_ff) begin
         ok = prefix_ok && !string_bad_ff && (octets_seen_ff == OCTET_COUNT);
      end else begin
         ok = !octet_bad && !string_bad_ff && (octets_closed == OCTET_COUNT);
      end
      verdict.done       = step && end_marker;
      verdict.cidr_valid = ok;
   end

   // Next state for a character transfer; an end marker clears everything.
   always_comb begin
      in_prefix_in          = in_prefix_ff;
      octet_value_in        = octet_value_ff;
      octet_has_digit_in    = octet_has_digit_ff;
      octets_seen_in        = octets_seen_ff;
      prefix_value_in       = prefix_value_ff;
      prefix_digit_count_in = prefix_digit_count_ff;
      prefix_starts_zero_in = prefix_starts_zero_ff;
      string_bad_in         = string_bad_ff;
      if (end_marker) begin
         in_prefix_in          = 1'b0;
         octet_value_in        = 9'd0;
         octet_has_digit_in    = 1'b0;
         octets_seen_in        = 3'd0;
         prefix_value_in       = 6'd0;
         prefix_digit_count_in = 2'd0;
         prefix_starts_zero_in = 1'b0;
         string_bad_in         = 1'b0;
      end else if (in_prefix_ff) begin
         if (!char_class.is_digit) begin
            string_bad_in = 1'b1;
         end else begin
            if ((prefix_digit_count_ff == 2'd0) && (char_class.digit_val == 4'd0)) begin
               prefix_starts_zero_in = 1'b1;
            end
            if (prefix_digit_count_ff < PREFIX_CNT_SAT) begin
               prefix_digit_count_in = prefix_digit_count_ff + 2'd1;
            end
            prefix_value_in = (prefix_wide > 9'(PREFIX_SAT)) ? PREFIX_SAT
                                                             : prefix_wide[5:0];
         end
      end else if (char_class.is_digit) begin
         octet_has_digit_in = 1'b1;
         octet_value_in     = (octet_wide > 13'(OCTET_SAT)) ? OCTET_SAT
                                                            : octet_wide[8:0];
      end else if (char_class.is_dot || char_class.is_slash) begin
         if (octet_bad) begin
            string_bad_in = 1'b1;
         end
         octets_seen_in     = octets_closed;
         octet_value_in     = 9'd0;
         octet_has_digit_in = 1'b0;
         if (char_class.is_slash) begin
            in_prefix_in = 1'b1;
         end
      end else begin
         string_bad_in = 1'b1;
      end
   end

   // State registers advance on every accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_prefix_ff          <= 1'b0;
         octet_value_ff        <= 9'd0;
         octet_has_digit_ff    <= 1'b0;
         octets_seen_ff        <= 3'd0;
         prefix_value_ff       <= 6'd0;
         prefix_digit_count_ff <= 2'd0;
         prefix_starts_zero_ff <= 1'b0;
         string_bad_ff         <= 1'b0;
      end else if (step) begin
         in_prefix_ff          <= in_prefix_in;
         octet_value_ff        <= octet_value_in;
         octet_has_digit_ff    <= octet_has_digit_in;
         octets_seen_ff        <= octets_seen_in;
         prefix_value_ff       <= prefix_value_in;
         prefix_digit_count_ff <= prefix_digit_count_in;
         prefix_starts_zero_ff <= prefix_starts_zero_in;
         string_bad_ff         <= string_bad_in;
      end
   end

endmodule

[src/ipv4_cidr_text_validator_top.sv]
// Top level of the IPv4 CIDR text validator: handshake and result register.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+-------------------
//   req     | req_valid, req_stall, req_ch,           | in (stall is out)
//           | req_end_marker                          |
//   rsp     | rsp_valid, rsp_stall, rsp_cidr_valid    | out (stall is in)
//
// One character is taken per cycle; each transfer updates the scanner state
// registers. An end marker loads the verdict into the result register, visible
// on rsp the cycle after its transfer. Reset clears the scanner and the result
// valid. While a verdict waits under rsp_stall, character transfers continue
// and only a further end marker is stalled.
module ipv4_cidr_text_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_marker,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_cidr_valid
);
   import ipv4cv_pkg::*;

   char_class_type char_class;
   verdict_type    verdict;
   logic           req_accept;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_cidr_valid_ff, rsp_cidr_valid_in;

   // An end marker waits only while the result register holds a stalled verdict.
   assign req_stall  = req_end_marker && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   ipv4cv_char_class u_char_class (
      .ch         (req_ch),
      .char_class (char_class)
   );

   ipv4cv_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .end_marker (req_end_marker),
      .char_class (char_class),
      .verdict    (verdict)
   );

   // Result register: loads on a verdict, empties on an output transfer.
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_cidr_valid_in = rsp_cidr_valid_ff;
      if (verdict.done) begin
         rsp_valid_in      = 1'b1;
         rsp_cidr_valid_in = verdict.cidr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cidr_valid_ff <= rsp_cidr_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cidr_valid = rsp_cidr_valid_ff;

endmodule
